@@ sv/rbd_pkg.sv @@
`default_nettype none

package rbd_pkg;

   localparam int DATA_W  = 32;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;
   localparam int CAP_W   = 5;

   typedef logic [KIND_W-1:0]        kind_type;
   typedef logic [STAT_W-1:0]        status_type;
   typedef logic signed [DATA_W-1:0] word_type;

   localparam kind_type KIND_PUSH_BACK  = 2'd0;
   localparam kind_type KIND_PUSH_FRONT = 2'd1;
   localparam kind_type KIND_POP_BACK   = 2'd2;
   localparam kind_type KIND_POP_FRONT  = 2'd3;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

@@ sv/rbd_req_if.sv @@
`default_nettype none

interface rbd_req_if import rbd_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type kind;
   word_type data;

   modport source (output valid, output kind, output data, input ready);
   modport sink   (input valid, input kind, input data, output ready);
endinterface

`default_nettype wire

@@ sv/rbd_rsp_if.sv @@
`default_nettype none

interface rbd_rsp_if import rbd_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [COUNT_W-1:0] count;
   word_type           front_value;
   word_type           back_value;

   modport source (output valid, output status, output count, output front_value,
                   output back_value, input ready);
   modport sink   (input valid, input status, input count, input front_value,
                   input back_value, output ready);
endinterface

`default_nettype wire

@@ sv/rbd_mem.sv @@
`default_nettype none

// Entry store: one write port, two registered read ports (old data on collision).
module rbd_mem import rbd_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire word_type                 wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      word_type                 rd_data_a,
   output      word_type                 rd_data_b
);

   word_type mem [DEPTH];
   word_type rd_a_ff;
   word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

@@ sv/ring_buffer_deque_core.sv @@
`default_nettype none

// A result beat appears in the cycle after its request beat is accepted.
// Throughput: one operation per cycle; a stalled result holds off the next request.
// The single entry memory (one write, two registered reads) sets that figure.
// Reset (synchronous, active high): queue empty, both indices 0, capacity 16
// (or DEPTH if smaller). Entry contents are not cleared.
module ring_buffer_deque_core import rbd_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   rbd_req_if.sink               req_bus,
   rbd_rsp_if.source             rsp_bus,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   localparam int IW = $clog2(DEPTH);       // entry index
   localparam int CW = $clog2(DEPTH + 1);   // count / capacity, holds DEPTH itself
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
   localparam logic [CW-1:0] CAP_RST =
      (EW'(CAP_RESET) > DEPTH_E) ? CW'(DEPTH) : CW'(CAP_RESET);

   // ---------------------------------------------------------------
   // Capacity register, stored already clamped to 1..DEPTH
   // ---------------------------------------------------------------
   logic [CW-1:0] cap_ff;
   logic [CW-1:0] cap_in;
   logic [EW-1:0] csr_e;

   always_comb begin
      csr_e = EW'(csr_wr_data);
      if (csr_e == '0) begin
         cap_in = CW'(1);
      end else if (csr_e > DEPTH_E) begin
         cap_in = CW'(DEPTH);
      end else begin
         cap_in = CW'(csr_e);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RST;
      end else if (csr_wr_en) begin
         cap_ff <= cap_in;
      end
   end

   // ---------------------------------------------------------------
   // Queue pointers and fill count
   // ---------------------------------------------------------------
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] held_ff, held_in;

   logic          rsp_valid_ff;
   logic          accept;

   // result-side registers
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff;
   logic               empty_ff;
   logic               fwd_front_ff, fwd_back_ff;
   logic               fwd_front_in, fwd_back_in;
   word_type           wdata_ff;

   // memory write side
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   word_type      rd_front, rd_back;

   logic is_push, is_full, is_empty;

   // Index stepping; a stale index beyond a shrunk capacity wraps to the ends.
   function automatic logic [IW-1:0] step_up(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt >= cap) ? '0 : IW'(nxt);
   endfunction

   function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] cap);
      return (idx == '0 || CW'(idx) > cap) ? IW'(cap - CW'(1)) : idx - IW'(1);
   endfunction

   assign accept   = req_bus.valid && req_bus.ready;
   assign is_push  = !req_bus.kind[1];
   assign is_full  = held_ff >= cap_ff;
   assign is_empty = held_ff == '0;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      held_in   = held_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = '0;
      if (is_push) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else if (is_empty) begin
            // first entry always lands at index 0
            head_in = '0;
            tail_in = '0;
            held_in = CW'(1);
            wr_en   = 1'b1;
         end else if (req_bus.kind == KIND_PUSH_BACK) begin
            tail_in = step_up(tail_ff, cap_ff);
            held_in = held_ff + CW'(1);
            wr_en   = 1'b1;
            wr_addr = tail_in;
         end else begin
            head_in = step_down(head_ff, cap_ff);
            held_in = held_ff + CW'(1);
            wr_en   = 1'b1;
            wr_addr = head_in;
         end
      end else begin
         if (is_empty) begin
            status_in = STATUS_EMPTY;
         end else if (held_ff == CW'(1)) begin
            head_in = '0;
            tail_in = '0;
            held_in = '0;
         end else if (req_bus.kind == KIND_POP_BACK) begin
            tail_in = step_down(tail_ff, cap_ff);
            held_in = held_ff - CW'(1);
         end else begin
            head_in = step_up(head_ff, cap_ff);
            held_in = held_ff - CW'(1);
         end
      end
      // the memory read sees pre-write data, so pushed data is forwarded
      fwd_front_in = wr_en && (wr_addr == head_in);
      fwd_back_in  = wr_en && (wr_addr == tail_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         held_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         held_ff <= held_in;
      end
   end

   // ---------------------------------------------------------------
   // Entry memory: write the pushed word, read new front and back
   // ---------------------------------------------------------------
   rbd_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock     (clock),
      .wr_en     (accept && wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_bus.data),
      .rd_en     (accept),
      .rd_addr_a (head_in),
      .rd_addr_b (tail_in),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   // ---------------------------------------------------------------
   // Result beat: a single output register, refilled as it drains
   // ---------------------------------------------------------------
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         count_ff     <= COUNT_W'(held_in);
         empty_ff     <= held_in == '0;
         fwd_front_ff <= fwd_front_in;
         fwd_back_ff  <= fwd_back_in;
         wdata_ff     <= req_bus.data;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.count       = count_ff;
   assign rsp_bus.front_value = empty_ff ? '0 : (fwd_front_ff ? wdata_ff : rd_front);
   assign rsp_bus.back_value  = empty_ff ? '0 : (fwd_back_ff ? wdata_ff : rd_back);

endmodule

`default_nettype wire

@@ tb/ring_buffer_deque_core_tb.sv @@
`timescale 1ns / 100ps

module ring_buffer_deque_core_tb;
   import rbd_pkg::*;

   localparam int          SLOTS      = 16;   // DEPTH of the block under test
   localparam int          PHASES     = 10;   // capacity settings in the random part
   localparam int          PHASE_OPS  = 200;  // operations per setting
   localparam int          CALM_PHASE = 3;    // no idling on either side here
   localparam int unsigned LIMIT_NS   = 2_000_000;

   // One result beat as the block shows it.
   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] count;
      word_type           front_value;
      word_type           back_value;
   } deque_view_t;

   // Row of the directed table; pinned rows carry a hand-written result.
   typedef struct {
      kind_type    kind;
      word_type    data;
      bit          pinned;
      deque_view_t want;
   } plan_row_t;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;
   logic             sink_ready = 1'b0;

   rbd_req_if req_bus ();
   rbd_rsp_if rsp_bus ();

   assign rsp_bus.ready = sink_ready;

   ring_buffer_deque_core #(
      .DEPTH (SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow deque: our own copy of the ring, its indices and the capacity.
   // ---------------------------------------------------------------------
   word_type         ring [SLOTS];
   int unsigned      head_at;
   int unsigned      tail_at;
   int unsigned      held;
   logic [CAP_W-1:0] cap_reg;

   deque_view_t owed_views [$];   // results still to arrive, oldest first
   bit          steady;           // idling switched off on both sides
   int unsigned beats_seen;
   int unsigned bad_beats;
   int unsigned full_refusals;
   int unsigned empty_refusals;
   int unsigned ops_sent;

   // Index moves; an index at or past the wrap point falls back to the ends.
   function automatic int unsigned step_up(int unsigned i, int unsigned lim);
      return (i + 1 >= lim) ? 0 : i + 1;
   endfunction

   function automatic int unsigned step_down(int unsigned i, int unsigned lim);
      return (i == 0 || i > lim) ? lim - 1 : i - 1;
   endfunction

   // Applies one operation to the shadow deque and returns the view after it.
   function automatic deque_view_t deque_step(kind_type k, word_type d);
      int unsigned lim;
      deque_view_t v;
      // capacity 0 behaves as 1, anything above DEPTH as DEPTH
      lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : int'(cap_reg));
      v.status = STATUS_DONE;
      if (k == KIND_PUSH_BACK || k == KIND_PUSH_FRONT) begin
         if (held >= lim) begin
            v.status = STATUS_FULL;
         end else if (held == 0) begin
            // first entry always lands in slot 0, both ends on it
            head_at = 0;
            tail_at = 0;
            ring[0] = d;
            held    = 1;
         end else if (k == KIND_PUSH_BACK) begin
            tail_at       = step_up(tail_at, lim);
            ring[tail_at] = d;
            held++;
         end else begin
            head_at       = step_down(head_at, lim);
            ring[head_at] = d;
            held++;
         end
      end else begin
         if (held == 0) begin
            v.status = STATUS_EMPTY;
         end else if (held == 1) begin
            // last one out: ends go home
            head_at = 0;
            tail_at = 0;
            held    = 0;
         end else if (k == KIND_POP_BACK) begin
            tail_at = step_down(tail_at, lim);
            held--;
         end else begin
            head_at = step_up(head_at, lim);
            held--;
         end
      end
      v.count       = held[COUNT_W-1:0];
      v.front_value = (held == 0) ? '0 : ring[head_at];
      v.back_value  = (held == 0) ? '0 : ring[tail_at];
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Called just after a rising edge; returns just after the
   // edge that took the beat, leaving valid high so that a following beat
   // needs no second assignment in that step. Handshakes are judged at the
   // falling edge, where nothing is moving.
   // ---------------------------------------------------------------------
   task automatic send_op(kind_type k, word_type d, bit pinned, deque_view_t want);
      deque_view_t view;
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= k;
      req_bus.data  <= d;
      @(negedge clock);
      while (!req_bus.ready) begin
         @(negedge clock);
      end
      view = deque_step(k, d);
      owed_views.push_back(pinned ? want : view);
      ops_sent++;
      @(posedge clock);
   endtask

   // Holds the request side off until every owed result has been taken.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (owed_views.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure, and a checker on every beat.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sink_ready <= !reset && (steady || $urandom_range(0, 99) >= 15);
   end

   always @(negedge clock) begin
      deque_view_t want;
      bit          stray;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_seen++;
         stray = (owed_views.size() == 0);
         want  = '0;
         if (!stray) begin
            want = owed_views.pop_front();
         end
         if (rsp_bus.status == STATUS_FULL)  full_refusals++;
         if (rsp_bus.status == STATUS_EMPTY) empty_refusals++;
         if (stray || rsp_bus.status !== want.status || rsp_bus.count !== want.count
             || rsp_bus.front_value !== want.front_value
             || rsp_bus.back_value !== want.back_value) begin
            bad_beats++;
            if (bad_beats <= 10) begin
               if (stray) begin
                  $display("%0t: result beat %0d with nothing owed", $realtime, beats_seen);
               end else begin
                  $display("%0t: beat %0d status %0d/%0d count %0d/%0d front %h/%h back %h/%h",
                           $realtime, beats_seen, want.status, rsp_bus.status,
                           want.count, rsp_bus.count, want.front_value, rsp_bus.front_value,
                           want.back_value, rsp_bus.back_value);
                  $display("   (expected/actual)");
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      plan_row_t   plan [$];
      kind_type    k;
      word_type    d;
      bit          grow;
      bit          push;
      int unsigned run;
      int unsigned left;
      int unsigned fill;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_PUSH_BACK;
      req_bus.data  <= '0;
      steady         = 1'b0;
      beats_seen     = 0;
      bad_beats      = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      ops_sent       = 0;
      head_at        = 0;
      tail_at        = 0;
      held           = 0;
      cap_reg        = CAP_RESET;
      foreach (ring[i]) ring[i] = '0;

      // Directed table. Capacity is at its reset value of 16 throughout.
      // Pops on an empty deque, a single beat in and out at the negative extreme, then one in at the positive.
      plan.push_back('{KIND_POP_FRONT, 32'sd0, 1'b1,
                       '{STATUS_EMPTY, 5'd0, 32'sd0, 32'sd0}});
      plan.push_back('{KIND_POP_BACK, 32'sd0, 1'b1,
                       '{STATUS_EMPTY, 5'd0, 32'sd0, 32'sd0}});
      plan.push_back('{KIND_PUSH_BACK, 32'sh8000_0000, 1'b1,
                       '{STATUS_DONE, 5'd1, 32'sh8000_0000, 32'sh8000_0000}});
      plan.push_back('{KIND_POP_FRONT, 32'sd0, 1'b1,
                       '{STATUS_DONE, 5'd0, 32'sd0, 32'sd0}});
      plan.push_back('{KIND_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1,
                       '{STATUS_DONE, 5'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}});
      // Front push from slot 0 wraps the head round to the top slot.
      plan.push_back('{KIND_PUSH_FRONT, -32'sd1, 1'b0, '0});
      plan.push_back('{KIND_PUSH_BACK, 32'sd0, 1'b0, '0});
      // Fill to the brim from both ends: afterwards every slot has been
      // written, so later capacity changes never expose a stale slot.
      for (fill = 0; fill < 13; fill++) begin
         plan.push_back('{(fill % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                          (fill % 2) ? 32'sh5555_5555 + fill : 32'shAAAA_AAAA - fill,
                          1'b0, '0});
      end
      // Refused pushes at both ends, then a pop from each end.
      plan.push_back('{KIND_PUSH_BACK, 32'sh1234_5678, 1'b0, '0});
      plan.push_back('{KIND_PUSH_FRONT, 32'sh0F0F_0F0F, 1'b0, '0});
      plan.push_back('{KIND_POP_BACK, 32'sd0, 1'b0, '0});
      plan.push_back('{KIND_POP_FRONT, 32'sd0, 1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_op(plan[i].kind, plan[i].data, plan[i].pinned, plan[i].want);
      end

      // Random part: one capacity per phase, written with the block idle and
      // the deque left as it is, so shrinking below the fill level is covered.
      // Bursts lean towards push or pop to reach both full and empty.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         csr_wr_en   <= 1'b1;
         case (ph)
            0: csr_wr_data <= 5'd1;
            1: csr_wr_data <= 5'd0;
            2: csr_wr_data <= 5'd31;
            3: csr_wr_data <= 5'd16;
            4: csr_wr_data <= 5'd5;
            5: csr_wr_data <= 5'd17;
            6: csr_wr_data <= 5'd2;
            default: csr_wr_data <= 5'($urandom_range(0, 31));
         endcase
         @(posedge clock);
         csr_wr_en <= 1'b0;
         cap_reg    = csr_wr_data;
         steady     = (ph == CALM_PHASE);
         left       = PHASE_OPS;
         while (left > 0) begin
            run  = $urandom_range(1, 20);
            grow = $urandom_range(0, 1);
            for (int j = 0; j < run && left > 0; j++) begin
               push = grow ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
               if (push) k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
               else      k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
               case ($urandom_range(0, 15))
                  0:       d = 32'sh8000_0000;
                  1:       d = 32'sh7FFF_FFFF;
                  2:       d = '0;
                  3:       d = '1;
                  default: d = $urandom;
               endcase
               send_op(k, d, 1'b0, '0);
               left--;
               // occasional full stop on the request side mid-phase
               if ($urandom_range(0, 299) == 0) drain();
            end
         end
      end

      steady = 1'b0;
      drain();
      repeat (2) @(posedge clock);

      $display("%0d operations over %0d capacity settings, %0d result beats checked",
               ops_sent, PHASES + 1, beats_seen);
      $display("%0d pushes refused as full, %0d pops refused as empty, %0d bad beats",
               full_refusals, empty_refusals, bad_beats);
      if (bad_beats == 0 && owed_views.size() == 0) begin
         $display("ring_buffer_deque_core test passed");
      end else begin
         $display("ring_buffer_deque_core test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(LIMIT_NS);
      $display("%0t: timed out with %0d results owed", $realtime, owed_views.size());
      $display("ring_buffer_deque_core test failed");
      $finish;
   end

endmodule
